@@ rtl/core/sih_pkg.sv @@
// Shared constants, types and register codes of the spin-image histogram block.
package sih_pkg;

    localparam int BINS_PER_AXIS = 16;
    localparam int COUNT_WIDTH   = 20;
    localparam int BIN_W         = $clog2(BINS_PER_AXIS);
    localparam int HIST_DEPTH    = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);

    localparam int COORD_W       = 32;
    localparam int DIFF_W        = 33;
    localparam int AXIS_W        = 18;
    localparam int INV_W         = 32;
    localparam int SEL_W         = 8;
    localparam int BIN_FIELD_W   = 4;
    localparam int COUNT_FIELD_W = 20;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_DATA_W     = 104;
    localparam int OUT_DATA_W    = 32;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_X      = 3'd0,
        CFG_CENTRE_Y      = 3'd1,
        CFG_CENTRE_Z      = 3'd2,
        CFG_AXIS_X        = 3'd3,
        CFG_AXIS_Y        = 3'd4,
        CFG_AXIS_Z        = 3'd5,
        CFG_INV_BIN_WIDTH = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
        logic signed [COORD_W-1:0] centre_z;
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_z;
        logic [INV_W-1:0]          inv_bin_width;
    } cfg_t;

    // One classified item: offset magnitudes and signs, or a bin to read.
    typedef struct packed {
        logic                   kind;
        logic [SEL_W-1:0]       sel;
        logic [2:0]             neg;
        logic [2:0][DIFF_W-1:0] mag;
    } entry_t;

endpackage

@@ rtl/core/sih_front.sv @@
// Front end: accepts input beats and turns points into offset magnitudes and signs.
module sih_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sih_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  sih_pkg::cfg_t                    cfg,
    input  logic                             queue_full,
    output logic                             push,
    output sih_pkg::entry_t                  push_entry
);
    import sih_pkg::*;

    logic signed [COORD_W-1:0] pos [3];
    logic signed [COORD_W-1:0] ctr [3];
    logic signed [DIFF_W-1:0]  diff [3];

    assign pos[0] = s_tdata[COORD_W-1:0];
    assign pos[1] = s_tdata[2*COORD_W-1:COORD_W];
    assign pos[2] = s_tdata[3*COORD_W-1:2*COORD_W];
    assign ctr[0] = cfg.centre_x;
    assign ctr[1] = cfg.centre_y;
    assign ctr[2] = cfg.centre_z;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        push_entry      = '0;
        push_entry.kind = s_tuser;
        push_entry.sel  = s_tdata[3*COORD_W+SEL_W-1:3*COORD_W];
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = DIFF_W'(pos[i]) - DIFF_W'(ctr[i]);
            push_entry.neg[i] = diff[i][DIFF_W-1];
            push_entry.mag[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
        end
    end

endmodule

@@ rtl/core/sih_queue.sv @@
// Short queue between the front end and the histogram engine.
module sih_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sih_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output sih_pkg::entry_t head
);
    import sih_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/sih_back.sv @@
// Histogram engine: shared multiplier, serial square root and bin memory update.
module sih_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sih_pkg::cfg_t                  cfg,
    input  logic                           q_empty,
    input  sih_pkg::entry_t                q_head,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sih_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sih_pkg::*;

    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DOT_W    = 54;
    localparam int DD_W     = 66;
    localparam int R_W      = 52;
    localparam int HALF_W   = R_W / 2;
    localparam int H2_W     = 2 * R_W;
    localparam int REM_W    = R_W + 4;
    localparam int QP_W     = R_W + INV_W;
    localparam int QSHIFT   = 48;
    localparam int SQ_CNT_W = $clog2(R_W);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_H2, ST_SQRT, ST_RD, ST_WR, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_DOT_X, OP_DOT_Y, OP_DOT_Z,
        OP_DD_X, OP_DD_Y, OP_DD_Z,
        OP_R2_LL, OP_R2_HL, OP_R2_HH,
        OP_QR_LO, OP_QR_HI, OP_QH_LO, OP_QH_HI
    } op_t;

    state_t                   state_reg;
    op_t                      op_reg;
    entry_t                   ent_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [DD_W-1:0]          dd_reg;
    logic [R_W-1:0]           r_reg;
    logic [H2_W-1:0]          r2_reg;
    logic [H2_W-1:0]          h2_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [R_W-1:0]           root_reg;
    logic [SQ_CNT_W-1:0]      sq_cnt_reg;
    logic [QP_W-1:0]          q_reg;
    logic [BIN_W-1:0]         rb_reg;
    logic [BIN_W-1:0]         hb_reg;
    logic                     hit_vld_reg;
    logic [COUNT_WIDTH-1:0]   res_cnt_reg;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic [HIST_DEPTH-1:0]    valid_reg;

    logic [COUNT_WIDTH-1:0]   hist_mem [HIST_DEPTH];
    logic [COUNT_WIDTH-1:0]   mem_rdata_reg;

    logic [AXIS_W-1:0]        axis_mag [3];
    logic [2:0]               axis_neg;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [R_W-1:0]           qval;
    logic                     dot_neg;
    logic signed [DOT_W-1:0]  dot_next;
    logic [DD_W-1:0]          dd_next;
    logic [H2_W-1:0]          r2_next;
    logic [QP_W-1:0]          q_next;
    logic [H2_W-1:0]          dd64;
    logic [REM_W-1:0]         rem_shift;
    logic [REM_W-1:0]         trial;
    logic [HIST_AW-1:0]       hist_idx;
    logic                     sel_ok;
    logic [COUNT_WIDTH-1:0]   cur_cnt;
    logic [COUNT_WIDTH-1:0]   cnt_next;
    logic                     mem_we;

    function automatic logic [BIN_W-1:0] clamp_bin(input logic [QP_W-1:0] p);
        logic [QP_W-QSHIFT-1:0] whole;
        whole = p[QP_W-1:QSHIFT];
        if (whole > (QP_W-QSHIFT)'(BINS_PER_AXIS - 1))
        begin
            return BIN_W'(BINS_PER_AXIS - 1);
        end
        return whole[BIN_W-1:0];
    endfunction

    assign axis_neg[0] = cfg.axis_x[AXIS_W-1];
    assign axis_neg[1] = cfg.axis_y[AXIS_W-1];
    assign axis_neg[2] = cfg.axis_z[AXIS_W-1];
    assign axis_mag[0] = axis_neg[0] ? AXIS_W'(-cfg.axis_x) : AXIS_W'(cfg.axis_x);
    assign axis_mag[1] = axis_neg[1] ? AXIS_W'(-cfg.axis_y) : AXIS_W'(cfg.axis_y);
    assign axis_mag[2] = axis_neg[2] ? AXIS_W'(-cfg.axis_z) : AXIS_W'(cfg.axis_z);

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        qval  = (op_reg == OP_QH_LO || op_reg == OP_QH_HI) ? root_reg : r_reg;
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_DOT_X: begin mul_a = ent_reg.mag[0]; mul_b = MUL_W'(axis_mag[0]); end
            OP_DOT_Y: begin mul_a = ent_reg.mag[1]; mul_b = MUL_W'(axis_mag[1]); end
            OP_DOT_Z: begin mul_a = ent_reg.mag[2]; mul_b = MUL_W'(axis_mag[2]); end
            OP_DD_X:  begin mul_a = ent_reg.mag[0]; mul_b = ent_reg.mag[0]; end
            OP_DD_Y:  begin mul_a = ent_reg.mag[1]; mul_b = ent_reg.mag[1]; end
            OP_DD_Z:  begin mul_a = ent_reg.mag[2]; mul_b = ent_reg.mag[2]; end
            OP_R2_LL:
            begin
                mul_a = MUL_W'(r_reg[HALF_W-1:0]);
                mul_b = MUL_W'(r_reg[HALF_W-1:0]);
            end
            OP_R2_HL:
            begin
                mul_a = MUL_W'(r_reg[R_W-1:HALF_W]);
                mul_b = MUL_W'(r_reg[HALF_W-1:0]);
            end
            OP_R2_HH:
            begin
                mul_a = MUL_W'(r_reg[R_W-1:HALF_W]);
                mul_b = MUL_W'(r_reg[R_W-1:HALF_W]);
            end
            OP_QR_LO, OP_QH_LO:
            begin
                mul_a = MUL_W'(qval[HALF_W-1:0]);
                mul_b = MUL_W'(cfg.inv_bin_width);
            end
            OP_QR_HI, OP_QH_HI:
            begin
                mul_a = MUL_W'(qval[R_W-1:HALF_W]);
                mul_b = MUL_W'(cfg.inv_bin_width);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Accumulation of the registered product.
    always_comb
    begin
        case (op_reg)
            OP_DOT_X: dot_neg = ent_reg.neg[0] ^ axis_neg[0];
            OP_DOT_Y: dot_neg = ent_reg.neg[1] ^ axis_neg[1];
            default:  dot_neg = ent_reg.neg[2] ^ axis_neg[2];
        endcase
        dot_next = dot_neg ? dot_reg - $signed(DOT_W'(prod_reg))
                           : dot_reg + $signed(DOT_W'(prod_reg));
        dd_next  = dd_reg + DD_W'(prod_reg);
        case (op_reg)
            OP_R2_HL: r2_next = r2_reg + (H2_W'(prod_reg) << (HALF_W + 1));
            OP_R2_HH: r2_next = r2_reg + (H2_W'(prod_reg) << (2 * HALF_W));
            default:  r2_next = r2_reg + H2_W'(prod_reg);
        endcase
        if (op_reg == OP_QR_HI || op_reg == OP_QH_HI)
        begin
            q_next = q_reg + (QP_W'(prod_reg) << HALF_W);
        end
        else
        begin
            q_next = q_reg + QP_W'(prod_reg);
        end
    end

    // Square root step, difference and bin memory addressing.
    always_comb
    begin
        dd64      = H2_W'(dd_reg) << 32;
        rem_shift = {rem_reg[REM_W-3:0], h2_reg[H2_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        if (ent_reg.kind)
        begin
            hist_idx = HIST_AW'(ent_reg.sel);
            sel_ok   = (int'(ent_reg.sel) < HIST_DEPTH);
        end
        else
        begin
            hist_idx = HIST_AW'(int'(hb_reg) * BINS_PER_AXIS + int'(rb_reg));
            sel_ok   = 1'b1;
        end
        cur_cnt  = hit_vld_reg ? mem_rdata_reg : '0;
        cnt_next = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
        mem_we   = (state_reg == ST_WR) && !ent_reg.kind;
    end

    always_ff @(posedge clk)
    begin
        mem_rdata_reg <= hist_mem[hist_idx];
        if (mem_we)
        begin
            hist_mem[hist_idx] <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_DOT_X;
            ent_reg      <= '0;
            prod_reg     <= '0;
            dot_reg      <= '0;
            dd_reg       <= '0;
            r_reg        <= '0;
            r2_reg       <= '0;
            h2_reg       <= '0;
            rem_reg      <= '0;
            root_reg     <= '0;
            sq_cnt_reg   <= '0;
            q_reg        <= '0;
            rb_reg       <= '0;
            hb_reg       <= '0;
            hit_vld_reg  <= 1'b0;
            res_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        ent_reg <= q_head;
                        dot_reg <= '0;
                        dd_reg  <= '0;
                        r2_reg  <= '0;
                        q_reg   <= '0;
                        rb_reg  <= '0;
                        hb_reg  <= '0;
                        op_reg  <= OP_DOT_X;
                        state_reg <= q_head.kind ? ST_RD : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(mul_a * mul_b);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    case (op_reg)
                        OP_DOT_X, OP_DOT_Y, OP_DOT_Z: dot_reg <= dot_next;
                        OP_DD_X, OP_DD_Y, OP_DD_Z:    dd_reg  <= dd_next;
                        OP_R2_LL, OP_R2_HL, OP_R2_HH: r2_reg  <= r2_next;
                        default:                      q_reg   <= q_next;
                    endcase
                    op_reg    <= op_t'(op_reg + 1'b1);
                    state_reg <= ST_MUL;
                    if (op_reg == OP_DD_Z)
                    begin
                        r_reg <= R_W'(dot_reg[DOT_W-1] ? -dot_reg : dot_reg);
                    end
                    if (op_reg == OP_R2_HH)
                    begin
                        state_reg <= ST_H2;
                    end
                    if (op_reg == OP_QR_HI)
                    begin
                        rb_reg     <= clamp_bin(q_next);
                        q_reg      <= '0;
                        rem_reg    <= '0;
                        root_reg   <= '0;
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQRT;
                    end
                    if (op_reg == OP_QH_HI)
                    begin
                        hb_reg    <= clamp_bin(q_next);
                        op_reg    <= OP_DOT_X;
                        state_reg <= ST_RD;
                    end
                end
                ST_H2:
                begin
                    h2_reg    <= (r2_reg <= dd64) ? dd64 - r2_reg : r2_reg - dd64;
                    state_reg <= ST_MUL;
                end
                ST_SQRT:
                begin
                    if (rem_shift >= trial)
                    begin
                        rem_reg  <= rem_shift - trial;
                        root_reg <= {root_reg[R_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_shift;
                        root_reg <= {root_reg[R_W-2:0], 1'b0};
                    end
                    h2_reg     <= h2_reg << 2;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == SQ_CNT_W'(R_W - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_RD:
                begin
                    hit_vld_reg <= valid_reg[hist_idx];
                    state_reg   <= ST_WR;
                end
                ST_WR:
                begin
                    if (ent_reg.kind)
                    begin
                        res_cnt_reg <= sel_ok ? cur_cnt : '0;
                        if (sel_ok)
                        begin
                            valid_reg[hist_idx] <= 1'b0;
                        end
                    end
                    else
                    begin
                        res_cnt_reg         <= cnt_next;
                        valid_reg[hist_idx] <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_DATA_W'({COUNT_FIELD_W'(res_cnt_reg),
                                                     BIN_FIELD_W'(hb_reg),
                                                     BIN_FIELD_W'(rb_reg)});
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/spin_image_histogram.sv @@
// Top level of the spin-image histogram block: configuration registers and module wiring.
//
// Usage: configure the centre point, its normal and the reciprocal bin width through
// the write port (cfg_we, cfg_index, cfg_data) while the block is idle. Then send item
// beats on the slave stream. s_tuser is the item kind: 0 accumulates the point in
// s_tdata into the 16x16 histogram, 1 reads the bin named in s_tdata and clears it.
// Every item produces exactly one result beat on the master stream, in order.
// A point passes through 13 products on one shared 33x33 multiplier, the difference, 52
// steps of the bit-serial square root, then a read-modify-write of the bin memory; a
// read only reads and clears its bin. The engine handles one item at a time and takes no
// new item until it has placed the last item's result in the output register.
// A two-beat queue lets the slave side accept items while the engine is busy, and the
// result sits in an output register, so the engine finishes the next item while the
// receiver stalls; it only waits if that register is still full.
// Reset clears the configuration to its defaults and empties the histogram at once
// through per-bin valid flags; no clearing pass is needed.
module spin_image_histogram (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sih_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sih_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64], bin_select[103:96].
    input  logic [sih_pkg::IN_DATA_W-1:0]      s_tdata,
    // Field: kind (0 accumulate point, 1 read and clear bin).
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: radial_bin[3:0], height_bin[7:4], bin_count[27:8], zero pad.
    output logic [sih_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import sih_pkg::*;

    cfg_t   cfg_reg;
    logic   push;
    entry_t push_entry;
    logic   queue_full;
    logic   queue_empty;
    logic   pop;
    entry_t head;

    // Configuration registers; unused index codes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_x      <= '0;
            cfg_reg.centre_y      <= '0;
            cfg_reg.centre_z      <= '0;
            cfg_reg.axis_x        <= '0;
            cfg_reg.axis_y        <= '0;
            cfg_reg.axis_z        <= AXIS_W'(65536);
            cfg_reg.inv_bin_width <= INV_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CENTRE_X:      cfg_reg.centre_x      <= cfg_data[COORD_W-1:0];
                CFG_CENTRE_Y:      cfg_reg.centre_y      <= cfg_data[COORD_W-1:0];
                CFG_CENTRE_Z:      cfg_reg.centre_z      <= cfg_data[COORD_W-1:0];
                CFG_AXIS_X:        cfg_reg.axis_x        <= cfg_data[AXIS_W-1:0];
                CFG_AXIS_Y:        cfg_reg.axis_y        <= cfg_data[AXIS_W-1:0];
                CFG_AXIS_Z:        cfg_reg.axis_z        <= cfg_data[AXIS_W-1:0];
                CFG_INV_BIN_WIDTH: cfg_reg.inv_bin_width <= cfg_data[INV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end classifies each beat and forms the offset from the centre.
    sih_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue decouples acceptance from the long-running engine.
    sih_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head       (head)
    );

    // The engine computes the bins, updates the histogram and holds the result beat.
    sih_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (queue_empty),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the spin-image histogram block.
`timescale 1ns / 100ps

module testbench;
    import sih_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 220;
    localparam int NUM_PHASES  = 7;

    typedef struct packed {
        logic                      is_read;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [SEL_W-1:0]          sel;
    } item_t;

    typedef struct packed {
        logic [BIN_FIELD_W-1:0]   rbin;
        logic [BIN_FIELD_W-1:0]   hbin;
        logic [COUNT_FIELD_W-1:0] count;
    } bin_result_t;

    // One directed row: the item, and a typed expectation where `known` is set.
    typedef struct packed {
        item_t       stim;
        logic        known;
        bin_result_t typed;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // Fields from bit 0: pos_x, pos_y, pos_z, bin_select.
    logic [IN_DATA_W-1:0]  s_tdata;
    // Field: kind.
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // Fields from bit 0: radial_bin, height_bin, bin_count, zero pad.
    logic [OUT_DATA_W-1:0] m_tdata;

    spin_image_histogram dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the configuration and of the bin memory.
    logic signed [COORD_W-1:0]  sh_cx, sh_cy, sh_cz;
    logic signed [AXIS_W-1:0]   sh_ax, sh_ay, sh_az;
    logic [INV_W-1:0]           sh_inv;
    logic [COUNT_FIELD_W-1:0]   sh_hist [HIST_DEPTH];

    bin_result_t pending_bins[$];

    int errors      = 0;
    int num_points  = 0;
    int num_reads   = 0;
    int idle_cycles = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit hold_req    = 0;
    int hold_left   = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Scale a Q.32 magnitude by the Q16.16 reciprocal bin width, floor and clamp.
    function automatic logic [BIN_FIELD_W-1:0] to_bin(input logic [63:0] q32);
        logic [127:0] prod;
        prod = 128'(q32) * 128'(sh_inv);
        prod = prod >> 48;
        return (prod > 128'(BINS_PER_AXIS - 1)) ? BIN_FIELD_W'(BINS_PER_AXIS - 1)
                                                : BIN_FIELD_W'(prod);
    endfunction

    // Applies one item to the shadow histogram and returns the beat it produces.
    function automatic bin_result_t histogram_update(input item_t it);
        bin_result_t res;
        logic signed [63:0] dx, dy, dz, dot;
        logic [63:0]  rmag, hroot, cand;
        logic [127:0] dd, r2, h2;
        int idx;
        res = '0;
        if (it.is_read) begin
            res.count = sh_hist[it.sel];
            sh_hist[it.sel] = '0;
            return res;
        end
        dx  = 64'(it.px) - 64'(sh_cx);
        dy  = 64'(it.py) - 64'(sh_cy);
        dz  = 64'(it.pz) - 64'(sh_cz);
        dot = dx * 64'(sh_ax) + dy * 64'(sh_ay) + dz * 64'(sh_az);
        rmag = magnitude(dot);
        dd = 128'(magnitude(dx)) * 128'(magnitude(dx))
           + 128'(magnitude(dy)) * 128'(magnitude(dy))
           + 128'(magnitude(dz)) * 128'(magnitude(dz));
        dd = dd << 32;
        r2 = 128'(rmag) * 128'(rmag);
        h2 = (r2 <= dd) ? dd - r2 : r2 - dd;
        // Bit-by-bit integer square root, truncating.
        hroot = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = hroot | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= h2)
                hroot = cand;
        end
        res.rbin = to_bin(rmag);
        res.hbin = to_bin(hroot);
        idx = int'(res.hbin) * BINS_PER_AXIS + int'(res.rbin);
        if (sh_hist[idx] != '1)
            sh_hist[idx] = sh_hist[idx] + 1'b1;
        res.count = sh_hist[idx];
        return res;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_CENTRE_X:      sh_cx  = val;
            CFG_CENTRE_Y:      sh_cy  = val;
            CFG_CENTRE_Z:      sh_cz  = val;
            CFG_AXIS_X:        sh_ax  = val[AXIS_W-1:0];
            CFG_AXIS_Y:        sh_ay  = val[AXIS_W-1:0];
            CFG_AXIS_Z:        sh_az  = val[AXIS_W-1:0];
            CFG_INV_BIN_WIDTH: sh_inv = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [31:0] ax,
                             input logic [31:0] ay, input logic [31:0] az,
                             input logic [31:0] inv);
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
        write_reg(CFG_CENTRE_Z, cz);
        write_reg(CFG_AXIS_X, ax);
        write_reg(CFG_AXIS_Y, ay);
        write_reg(CFG_AXIS_Z, az);
        write_reg(CFG_INV_BIN_WIDTH, inv);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one beat and waits for the handshake; s_tvalid stays high for the
    // next beat unless a gap is drawn.
    task automatic send_item(input item_t it, input logic known, input bin_result_t typed);
        bin_result_t exp_bins;
        s_tvalid <= 1'b1;
        s_tuser  <= it.is_read;
        s_tdata  <= {it.sel, it.pz, it.py, it.px};
        do @(posedge clk); while (!s_tready);
        exp_bins = histogram_update(it);
        pending_bins.insert(pending_bins.size(), known ? typed : exp_bins);
        if (it.is_read) num_reads++; else num_points++;
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Mostly points near the centre at a spread of scales, some anywhere, some reads.
    function automatic item_t random_item;
        item_t it;
        int shift;
        it.is_read = ($urandom_range(99) < 20);
        it.sel     = $urandom_range(255);
        shift      = $urandom_range(31, 8);
        if ($urandom_range(99) < 65) begin
            it.px = sh_cx + ($signed($urandom) >>> shift);
            it.py = sh_cy + ($signed($urandom) >>> shift);
            it.pz = sh_cz + ($signed($urandom) >>> shift);
        end else begin
            it.px = $urandom;
            it.py = $urandom;
            it.pz = $urandom;
        end
        return it;
    endfunction

    // Receiver side: random stalls, and a long hold-off on request.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: every beat against the oldest expectation.
    always @(posedge clk) begin
        bin_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_bins.size() == 0) begin
                $error("unexpected result beat %h", m_tdata);
                errors++;
            end else begin
                want = pending_bins.pop_front();
                if (m_tdata[3:0] !== want.rbin) begin
                    $error("radial_bin: expected %0d, got %0d", want.rbin, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[7:4] !== want.hbin) begin
                    $error("height_bin: expected %0d, got %0d", want.hbin, m_tdata[7:4]);
                    errors++;
                end
                if (m_tdata[27:8] !== want.count) begin
                    $error("bin_count: expected %0d, got %0d", want.count, m_tdata[27:8]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Directed rows under the reset configuration: centre at the origin, normal
    // along z, unit bin width.
    row_t dir_rows [0:15] = '{
        // Empty histogram after reset.
        '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 8'd0},   1'b1, '{4'd0, 4'd0, 20'd0}},
        '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 8'd255}, 1'b1, '{4'd0, 4'd0, 20'd0}},
        // Point on the centre, twice.
        '{'{1'b0, 32'sh0, 32'sh0, 32'sh0, 8'd0},   1'b1, '{4'd0, 4'd0, 20'd1}},
        '{'{1'b0, 32'sh0, 32'sh0, 32'sh0, 8'd0},   1'b1, '{4'd0, 4'd0, 20'd2}},
        // Coordinate extremes clamp to the last bin.
        '{'{1'b0, 32'sh7FFFFFFF, 32'sh0, 32'sh0, 8'd0}, 1'b1, '{4'd0, 4'd15, 20'd1}},
        '{'{1'b0, 32'sh0, 32'sh0, 32'sh80000000, 8'd0}, 1'b1, '{4'd15, 4'd0, 20'd1}},
        '{'{1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 8'd0},
          1'b1, '{4'd15, 4'd15, 20'd1}},
        '{'{1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 8'd0},
          1'b1, '{4'd15, 4'd15, 20'd2}},
        // r = 2.5 and h = 1 land in bin (2, 1).
        '{'{1'b0, 32'sh00010000, 32'sh0, 32'sh00028000, 8'd0}, 1'b1, '{4'd2, 4'd1, 20'd1}},
        // Read and clear, then read the cleared bin.
        '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 8'd18},  1'b1, '{4'd0, 4'd0, 20'd1}},
        '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 8'd18},  1'b1, '{4'd0, 4'd0, 20'd0}},
        '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 8'd255}, 1'b1, '{4'd0, 4'd0, 20'd2}},
        '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 8'd0},   1'b1, '{4'd0, 4'd0, 20'd2}},
        // Alternating bit patterns, checked by prediction.
        '{'{1'b0, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 8'd0}, 1'b0, '0},
        '{'{1'b0, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 8'd0}, 1'b0, '0},
        '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 8'hAA}, 1'b0, '0}
    };

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        sh_cx = '0; sh_cy = '0; sh_cz = '0;
        sh_ax = '0; sh_ay = '0; sh_az = AXIS_W'(65536);
        sh_inv = 32'd65536;
        foreach (sh_hist[i]) sh_hist[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(dir_rows); i++)
            send_item(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].typed);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Each phase picks a setting and an idling mode.
            case (ph)
                0: configure(0, 0, 0, 0, 0, 65536, 65536);
                1: configure(0, 0, 0, 0, 0, 65536, 32'h0004_0000);
                2: configure(32'h7FFFFFFF, 32'h80000000, 0, 65536, 0, 0, 32'hFFFFFFFF);
                3: configure($urandom, $urandom, $urandom, 0, 65536, 0, 0);
                4: configure($urandom, $urandom, $urandom, 32'hFFFE_0000, 32'h0001_FFFF,
                             12345, 32'h0000_8000);
                5: configure($urandom >> 4, $urandom >> 4, $urandom >> 4, -65536, 0, 0,
                             $urandom_range(32'h0010_0000, 32'h0000_4000));
                default: configure($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom);
            endcase
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 51; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 51; end
                default: begin gap_pct = 36; stall_pct = 36; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    hold_req = 1'b1;
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    while (pending_bins.size() != 0) @(posedge clk);
                end
                send_item(random_item(), 1'b0, '0);
            end
            drain();
        end

        $display("Covered %0d point beats and %0d read beats over %0d settings,",
                 num_points, num_reads, NUM_PHASES + 1);
        $display("including bin-width extremes, non-unit normals and back-pressure.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ spin_image_histogram.f @@
rtl/core/sih_pkg.sv
rtl/core/sih_front.sv
rtl/core/sih_queue.sv
rtl/core/sih_back.sv
rtl/core/spin_image_histogram.sv
tb/testbench.sv
